// File: rtl/rotating_slot_block_store_macros.svh
// Assertion macros used by the block store top level.
`ifndef ROTATING_SLOT_BLOCK_STORE_MACROS_SVH
`define ROTATING_SLOT_BLOCK_STORE_MACROS_SVH

// Same-cycle implication, checked on clk, muted while in reset.
`define RSBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, muted while in reset.
`define RSBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rsbs_pkg.sv
// Shared types, codes and defaults of the rotating slot block store.
package rsbs_pkg;

	// Default geometry
	localparam int BLOCK_COUNT_DEF = 16;
	localparam int BLOCK_BYTES_DEF = 32;
	localparam int SLOT_COUNT_DEF  = 3;

	localparam logic [7:0]  ERASED_BYTE = 8'hFF;
	localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_INVAL = 2'd2,
		MODE_ERASE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_REJECT  = 2'd1,
		STAT_INVALID = 2'd2
	} stat_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD_ADDR,
		ST_RD_DATA
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;   // latch input transaction, start meta read
		logic exec;      // carry out the request
		logic rd_issue;  // issue one byte read
		logic rd_push;   // push read byte to output
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;  // output register can take a result
		logic rd_ok;     // read request passed all checks
		logic rd_last;   // current read byte is the final one
	} dp_stat_t;

endpackage

// File: rtl/rotating_slot_block_store.sv
// Top level of the rotating slot block store: controller, datapath and checks.
// A transaction is accepted only while the block is idle. The block first reads the metadata
// (registered) and then executes the request; a write byte, invalidate, erase or rejected
// request ends there, after any wait for the output register to drain. An accepted read
// returns length bytes from the single-port byte store, each by an address step and then a
// registered data step. The output register lets a finished result wait while the next
// transaction is taken. The byte store needs no clearing pass after reset: a read only
// reaches bytes below the stored length of a valid block, and those were all written by the
// run that committed it.
module rotating_slot_block_store
	import rsbs_pkg::*;
#(
	parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
	parameter int SLOT_COUNT  = SLOT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  block,
	input  logic [7:0]  offset,
	input  logic [7:0]  length,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte_res,
	output logic [1:0]  status,
	output logic [31:0] write_total,
	output logic        last_res
);

`include "rotating_slot_block_store_macros.svh"

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rsbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rsbs_datapath #(
		.BLOCK_COUNT (BLOCK_COUNT),
		.BLOCK_BYTES (BLOCK_BYTES),
		.SLOT_COUNT  (SLOT_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.mode          (mode),
		.block         (block),
		.offset        (offset),
		.length        (length),
		.data_byte     (data_byte),
		.last          (last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.data_byte_res (data_byte_res),
		.status        (status),
		.write_total   (write_total),
		.last_res      (last_res)
	);

	// A read byte is only pushed when the output register can take it
	`RSBS_ASSERT_NOW(a_push_room, cmd.rd_push, (!out_valid || out_ready), "result overwritten")

	// An accepted transaction keeps the block busy for at least the next cycle
	`RSBS_ASSERT_NEXT(a_busy_after_accept, (in_valid && in_ready), !in_ready, "idle after accept")

	// While a non-final result is delivered, its read is still running
	`RSBS_ASSERT_NOW(a_mid_read_busy, out_valid && out_ready && !last_res, !in_ready, "idle in read")

endmodule

// File: rtl/rsbs_ctrl.sv
// Controller state machine of the rotating slot block store.
module rsbs_ctrl
	import rsbs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (stat.out_free) state_nxt = stat.rd_ok ? ST_RD_ADDR : ST_IDLE;
			end
			ST_RD_ADDR: begin
				state_nxt = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				if (stat.out_free) state_nxt = stat.rd_last ? ST_IDLE : ST_RD_ADDR;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = stat.out_free;
			end
			ST_RD_ADDR: begin
				cmd.rd_issue = 1'b1;
			end
			ST_RD_DATA: begin
				cmd.rd_push = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: rtl/rsbs_datapath.sv
// Datapath of the rotating slot block store: byte store, block metadata, run state, output.
module rsbs_datapath
	import rsbs_pkg::*;
#(
	parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
	parameter int SLOT_COUNT  = SLOT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [1:0]  mode,
	input  logic [7:0]  block,
	input  logic [7:0]  offset,
	input  logic [7:0]  length,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte_res,
	output logic [1:0]  status,
	output logic [31:0] write_total,
	output logic        last_res
);

	localparam int DEPTH  = BLOCK_COUNT * SLOT_COUNT * BLOCK_BYTES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BIDX_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int POS_W  = $clog2(BLOCK_BYTES + 1);
	localparam int META_W = POS_W + SLOT_W + 32;

	// Start address of one slot of one block
	function automatic logic [ADDR_W-1:0] slot_base(input logic [BIDX_W-1:0] b,
		input logic [SLOT_W-1:0] s);
		logic [ADDR_W-1:0] row;
		row = ADDR_W'(b) * ADDR_W'(SLOT_COUNT) + ADDR_W'(s);
		return row * ADDR_W'(BLOCK_BYTES);
	endfunction

	// Storage
	logic [7:0]        data_mem [DEPTH];
	logic [META_W-1:0] meta_mem [BLOCK_COUNT];
	logic [BLOCK_COUNT-1:0] meta_vld_q;    // meta entry written since reset
	logic [BLOCK_COUNT-1:0] blk_valid_q;

	// Captured transaction
	mode_t       mode_q;
	logic [7:0]  block_q;
	logic [7:0]  offset_q;
	logic [7:0]  length_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic [BIDX_W-1:0] meta_idx_q;
	logic [META_W-1:0] meta_rd_q;

	// Write run state
	logic              run_active_q;
	logic              run_ovf_q;
	logic [POS_W-1:0]  run_pos_q;
	logic [BIDX_W-1:0] run_block_q;

	// Read loop
	logic [ADDR_W-1:0] rd_base_q;
	logic [POS_W-1:0]  rd_idx_q;
	logic [7:0]        rd_data_q;

	// Output register
	logic        out_valid_q;
	logic [7:0]  out_data_q;
	logic [1:0]  out_stat_q;
	logic [31:0] out_total_q;
	logic        out_last_q;

	logic [BIDX_W-1:0] meta_raddr;
	logic [POS_W-1:0]  len_e;
	logic [SLOT_W-1:0] slot_e;
	logic [31:0]       cnt_e;
	logic [31:0]       cnt_inc;
	logic [SLOT_W-1:0] slot_nxt;
	logic              blk_oor;
	logic [8:0]        rd_end;
	logic              rd_reject;
	logic              rd_invalid;
	logic              wr_start;
	logic              ovf0;
	logic              ovf1;
	logic [POS_W-1:0]  pos0;
	logic [POS_W-1:0]  pos1;
	logic              can_wr;
	logic              data_we;
	logic [ADDR_W-1:0] data_waddr;
	logic [ADDR_W-1:0] data_raddr;
	logic              meta_we;
	logic [META_W-1:0] meta_wdata;
	logic              push;
	logic [7:0]        push_data;
	stat_code_t        push_stat;
	logic [31:0]       push_total;
	logic              push_last;

	// Meta read address: an open run keeps its own block
	assign meta_raddr = (mode_t'(mode) == MODE_WRITE && run_active_q) ?
		run_block_q : block[BIDX_W-1:0];

	// Effective metadata of the addressed block
	assign len_e    = meta_vld_q[meta_idx_q] ? meta_rd_q[META_W-1 -: POS_W] : '0;
	assign slot_e   = meta_vld_q[meta_idx_q] ? meta_rd_q[32 +: SLOT_W] : '0;
	assign cnt_e    = meta_vld_q[meta_idx_q] ? meta_rd_q[31:0] : '0;
	assign cnt_inc  = (cnt_e == COUNT_MAX) ? cnt_e : cnt_e + 32'd1;
	assign slot_nxt = (slot_e == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot_e + SLOT_W'(1);

	// Request checks
	assign blk_oor    = {1'b0, block_q} >= 9'(BLOCK_COUNT);
	assign rd_end     = 9'(offset_q) + 9'(length_q);
	assign rd_reject  = blk_oor || (length_q == 8'd0) || (length_q > 8'(BLOCK_BYTES)) ||
		(rd_end > 9'(BLOCK_BYTES));
	assign rd_invalid = !blk_valid_q[meta_idx_q] || (9'(len_e) < rd_end);

	// Write run step
	assign wr_start   = !run_active_q;
	assign ovf0       = wr_start ? blk_oor : run_ovf_q;
	assign pos0       = wr_start ? '0 : run_pos_q;
	assign can_wr     = !ovf0 && (pos0 < POS_W'(BLOCK_BYTES));
	assign ovf1       = ovf0 || !can_wr;
	assign pos1       = can_wr ? pos0 + POS_W'(1) : pos0;
	assign data_waddr = slot_base(meta_idx_q, slot_nxt) + ADDR_W'(pos0);
	assign data_we    = cmd.exec && (mode_q == MODE_WRITE) && can_wr;
	assign data_raddr = rd_base_q + ADDR_W'(rd_idx_q);

	// Metadata update and result selection
	always_comb begin
		meta_we    = 1'b0;
		meta_wdata = {len_e, slot_e, cnt_e};
		push       = 1'b0;
		push_data  = 8'd0;
		push_stat  = STAT_OK;
		push_total = 32'd0;
		push_last  = 1'b1;
		if (cmd.exec) begin
			case (mode_q)
				MODE_WRITE: begin
					if (last_q) begin
						push = 1'b1;
						if (ovf1) begin
							push_stat = STAT_REJECT;
						end else begin
							meta_we    = 1'b1;
							meta_wdata = {pos1, slot_nxt, cnt_inc};
							push_total = cnt_inc;
						end
					end
				end
				MODE_READ: begin
					push      = rd_reject || rd_invalid;
					push_stat = rd_reject ? STAT_REJECT : STAT_INVALID;
				end
				MODE_INVAL: begin
					push      = 1'b1;
					push_stat = blk_oor ? STAT_REJECT : STAT_INVALID;
				end
				default: begin
					push      = 1'b1;
					push_stat = blk_oor ? STAT_REJECT : STAT_OK;
					if (!blk_oor) begin
						meta_we    = 1'b1;
						meta_wdata = {POS_W'(0), SLOT_W'(0), cnt_e};
					end
				end
			endcase
		end else if (cmd.rd_push) begin
			push      = 1'b1;
			push_data = rd_data_q;
			push_last = stat.rd_last;
		end
	end

	// Memories: byte store and per-block metadata, registered reads
	always_ff @(posedge clk) begin
		if (data_we) data_mem[data_waddr] <= data_q;
		if (cmd.rd_issue) rd_data_q <= data_mem[data_raddr];
		if (meta_we) meta_mem[meta_idx_q] <= meta_wdata;
		if (cmd.capture) meta_rd_q <= meta_mem[meta_raddr];
	end

	// Captured transaction and read loop payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q     <= mode_t'(mode);
			block_q    <= block;
			offset_q   <= offset;
			length_q   <= length;
			data_q     <= data_byte;
			last_q     <= last;
			meta_idx_q <= meta_raddr;
		end
		if (cmd.exec) begin
			rd_base_q <= slot_base(meta_idx_q, slot_e) + ADDR_W'(offset_q);
			rd_idx_q  <= '0;
		end else if (cmd.rd_push) begin
			rd_idx_q  <= rd_idx_q + POS_W'(1);
		end
	end

	// Valid bits and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_vld_q   <= '0;
			blk_valid_q  <= '0;
			run_active_q <= 1'b0;
			run_ovf_q    <= 1'b0;
			run_pos_q    <= '0;
			run_block_q  <= '0;
		end else if (cmd.exec) begin
			if (meta_we) meta_vld_q[meta_idx_q] <= 1'b1;
			if (mode_q == MODE_WRITE) begin
				if (last_q) begin
					run_active_q <= 1'b0;
					run_ovf_q    <= 1'b0;
					if (!ovf1) blk_valid_q[meta_idx_q] <= 1'b1;
				end else begin
					run_active_q <= 1'b1;
					run_ovf_q    <= ovf1;
				end
				run_pos_q   <= pos1;
				run_block_q <= meta_idx_q;
			end else begin
				run_active_q <= 1'b0;
				run_ovf_q    <= 1'b0;
				run_pos_q    <= '0;
				if ((mode_q == MODE_INVAL || mode_q == MODE_ERASE) && !blk_oor) begin
					blk_valid_q[meta_idx_q] <= 1'b0;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_data_q  <= push_data;
			out_stat_q  <= push_stat;
			out_total_q <= push_total;
			out_last_q  <= push_last;
		end
	end

	// Status to controller
	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.rd_ok    = (mode_q == MODE_READ) && !rd_reject && !rd_invalid;
	assign stat.rd_last  = (9'(rd_idx_q) + 9'd1) == {1'b0, length_q};

	assign out_valid     = out_valid_q;
	assign data_byte_res = out_data_q;
	assign status        = out_stat_q;
	assign write_total   = out_total_q;
	assign last_res      = out_last_q;

endmodule
